/* sv/cdq_pkg.sv */
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque unit.
// ----------------------------------------------------------------------------
package cdq_pkg;

    // Fixed field widths
    localparam int CAP_W   = 9;
    localparam int FIELD_W = 32;

    // Request codes
    typedef enum logic [1:0] {
        REQ_PUSH_REAR  = 2'd0,
        REQ_PUSH_FRONT = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_REAR   = 2'd3
    } t_req_type;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Request beat
    typedef struct packed {
        t_req_type                   req_type;
        logic signed [FIELD_W-1:0]   push_value;
    } t_req;

    // Result beat
    typedef struct packed {
        t_status                     status;
        logic signed [FIELD_W-1:0]   popped_value;
        logic                        popped_valid;
    } t_rsp;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_RESULT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // request beat taken this cycle
    } t_cmd;

endpackage

/* sv/cdq_stream_if.sv */
// ----------------------------------------------------------------------------
// cdq_stream_if
// Valid/ready channel carrying one payload beat of a given type.
// ----------------------------------------------------------------------------
interface cdq_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/cdq_ram.sv */
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/cdq_ctrl.sv */
// ----------------------------------------------------------------------------
// cdq_ctrl
// Handshake controller: takes one request beat, then holds the result beat
// until the sink takes it.
// ----------------------------------------------------------------------------
module cdq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_rsp_ready,
    output logic          o_req_ready,
    output logic          o_rsp_valid,
    output cdq_pkg::t_cmd o_cmd
);
    import cdq_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_req_ready  = 1'b0;
        o_rsp_valid  = 1'b0;
        o_cmd.accept = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready  = 1'b1;
                o_cmd.accept = i_req_valid;
            end
            S_RESULT: begin
                o_rsp_valid = 1'b1;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end
endmodule

/* sv/cdq_dpath.sv */
// ----------------------------------------------------------------------------
// cdq_dpath
// Deque datapath: front/rear indices, empty flag, capacity, slot RAM and
// the result register.
// ----------------------------------------------------------------------------
module cdq_dpath #(
    parameter int MAX_DEPTH  = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]   i_cfg_wdata,
    input  cdq_pkg::t_cmd               i_cmd,
    input  cdq_pkg::t_req               i_req,
    output cdq_pkg::t_rsp               o_rsp
);
    import cdq_pkg::*;

    localparam int IW        = $clog2(MAX_DEPTH);
    localparam int CW        = $clog2(MAX_DEPTH + 1);
    localparam int CAPW      = (CW > CAP_W) ? CW : CAP_W;
    localparam int RESET_CAP = (MAX_DEPTH < 256) ? MAX_DEPTH : 256;

    // Control state
    logic [IW-1:0] r_front, n_front;
    logic [IW-1:0] r_rear,  n_rear;
    logic          r_empty, n_empty;
    logic [IW-1:0] r_cap_m1;            // capacity in use, minus one
    t_status       r_status, n_status;
    logic          r_pop_valid, n_pop_valid;

    // RAM port signals
    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [IW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    // Wrapped neighbors of the indices
    logic [IW-1:0] rear_next, rear_prev, front_next, front_prev;
    logic          full;
    logic [CAPW-1:0] cfg_ext;
    logic [IW-1:0]   cfg_cap_m1;

    assign rear_next  = (r_rear  == r_cap_m1) ? '0 : r_rear + 1'b1;
    assign rear_prev  = (r_rear  == '0) ? r_cap_m1 : r_rear - 1'b1;
    assign front_next = (r_front == r_cap_m1) ? '0 : r_front + 1'b1;
    assign front_prev = (r_front == '0) ? r_cap_m1 : r_front - 1'b1;
    assign full       = !r_empty && (rear_next == r_front);

    // Clamp a written capacity into 1..MAX_DEPTH
    assign cfg_ext = CAPW'(i_cfg_wdata);
    always_comb begin
        if (cfg_ext == '0) begin
            cfg_cap_m1 = '0;
        end else if (cfg_ext > CAPW'(MAX_DEPTH)) begin
            cfg_cap_m1 = IW'(MAX_DEPTH - 1);
        end else begin
            cfg_cap_m1 = IW'(cfg_ext - 1'b1);
        end
    end

    // Request decode and index update
    always_comb begin
        n_front     = r_front;
        n_rear      = r_rear;
        n_empty     = r_empty;
        n_status    = r_status;
        n_pop_valid = r_pop_valid;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_re      = 1'b0;
        ram_raddr   = r_front;
        if (i_cmd.accept) begin
            n_status    = ST_DONE;
            n_pop_valid = 1'b0;
            if (i_req.req_type inside {REQ_PUSH_REAR, REQ_PUSH_FRONT}) begin
                if (full) begin
                    n_status = ST_FULL;
                end else if (r_empty) begin
                    n_front = '0;
                    n_rear  = '0;
                    n_empty = 1'b0;
                    ram_we  = 1'b1;
                end else if (i_req.req_type == REQ_PUSH_REAR) begin
                    n_rear    = rear_next;
                    ram_we    = 1'b1;
                    ram_waddr = rear_next;
                end else begin
                    n_front   = front_prev;
                    ram_we    = 1'b1;
                    ram_waddr = front_prev;
                end
            end else begin
                if (r_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_pop_valid = 1'b1;
                    ram_re      = 1'b1;
                    ram_raddr   = (i_req.req_type == REQ_POP_FRONT) ? r_front : r_rear;
                    if (r_front == r_rear) begin
                        n_front = '0;
                        n_rear  = '0;
                        n_empty = 1'b1;
                    end else if (i_req.req_type == REQ_POP_FRONT) begin
                        n_front = front_next;
                    end else begin
                        n_rear = rear_prev;
                    end
                end
            end
        end
    end

    assign ram_wdata = DATA_WIDTH'($unsigned(i_req.push_value));

    // State registers; a capacity write also empties the deque
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_rear      <= '0;
            r_empty     <= 1'b1;
            r_cap_m1    <= IW'(RESET_CAP - 1);
            r_status    <= ST_DONE;
            r_pop_valid <= 1'b0;
        end else if (i_cfg_we) begin
            r_front  <= '0;
            r_rear   <= '0;
            r_empty  <= 1'b1;
            r_cap_m1 <= cfg_cap_m1;
        end else begin
            r_front     <= n_front;
            r_rear      <= n_rear;
            r_empty     <= n_empty;
            r_status    <= n_status;
            r_pop_valid <= n_pop_valid;
        end
    end

    // Slot store
    cdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Result beat; popped data comes straight from the RAM read register
    assign o_rsp.status       = r_status;
    assign o_rsp.popped_valid = r_pop_valid;
    assign o_rsp.popped_value = r_pop_valid ? FIELD_W'(ram_rdata) : '0;
endmodule

/* sv/circular_deque_unit.sv */
// ----------------------------------------------------------------------------
// circular_deque_unit
// Double-ended queue in a circular slot RAM with a configurable capacity.
//
//   Channel   Dir  Beat    Contents
//   i_req     in   t_req   req_type, push_value
//   o_rsp     out  t_rsp   status, popped_value, popped_valid
//   i_cfg_*   in   write   capacity (9 bits), empties the deque
//
// A request is taken in S_IDLE and its result beat is offered from registers in
// S_RESULT; the next request is taken once that result beat has left, so the
// unit takes no new request while a result is pending. S_RESULT also covers the
// registered RAM read that a pop needs before its value can be shown.
// Reset is synchronous: empty deque, capacity 256 (or MAX_DEPTH if smaller).
// The slot RAM is not cleared. A stalled result beat holds the input stalled.
// ----------------------------------------------------------------------------
module circular_deque_unit #(
    parameter int MAX_DEPTH  = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0] i_cfg_wdata,
    cdq_stream_if.sink                i_req,
    cdq_stream_if.source              o_rsp
);
    import cdq_pkg::*;

    t_cmd cmd;
    t_req req_beat;
    t_rsp rsp_beat;

    assign req_beat = i_req.data;
    assign o_rsp.data = rsp_beat;

    // Handshake controller
    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    // Deque datapath
    cdq_dpath #(
        .MAX_DEPTH  (MAX_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .i_req       (req_beat),
        .o_rsp       (rsp_beat)
    );
endmodule
